// ===== rtl/mmss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mmss_pkg;

  // Request kinds, carried on tuser
  localparam logic [1:0] KIND_TICK     = 2'd0;
  localparam logic [1:0] KIND_SHOW_TIME = 2'd1;
  localparam logic [1:0] KIND_SHOW_SET = 2'd2;
  localparam logic [1:0] KIND_BLINK    = 2'd3;

  // Blink modes
  localparam logic [1:0] BLINK_NONE    = 2'd0;
  localparam logic [1:0] BLINK_MINUTES = 2'd1;
  localparam logic [1:0] BLINK_SECONDS = 2'd2;
  localparam logic [1:0] BLINK_COLON   = 2'd3;

  // Setting ids
  localparam logic [1:0] SET_PRENOTIFY = 2'd0;
  localparam logic [1:0] SET_LONG      = 2'd1;
  localparam logic [1:0] SET_EACH_MIN  = 2'd2;

  // Letter patterns, gfedcba
  localparam logic [6:0] SEG_P     = 7'h73;
  localparam logic [6:0] SEG_N     = 7'h54;
  localparam logic [6:0] SEG_L     = 7'h38;
  localparam logic [6:0] SEG_E     = 7'h79;
  localparam logic [6:0] SEG_O     = 7'h3F;
  localparam logic [6:0] SEG_F     = 7'h71;
  localparam logic [6:0] SEG_BLANK = 7'h00;

  localparam logic [12:0] MAX_SECONDS = 13'd5999;
  localparam logic [6:0]  MAX_VALUE   = 7'd99;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd500;

  // 4369 / 2^18 sits just under 1/60, so the estimate is low by at most one
  localparam logic [12:0] RECIP_60 = 13'd4369;
  localparam int          RECIP_60_SHIFT = 18;
  // 205 / 2^11 is exact for division by ten below 1024
  localparam logic [7:0]  RECIP_10 = 8'd205;
  localparam int          RECIP_10_SHIFT = 11;

  typedef struct packed {
    logic        showing_setting;
    logic [15:0] seconds;
    logic [1:0]  setting_id;
    logic [7:0]  setting_value;
    logic [1:0]  mode;
    logic        phase;
  } view_t;

  typedef struct packed {
    logic       colon;
    logic [6:0] dig3;
    logic [6:0] dig2;
    logic [6:0] dig1;
    logic [6:0] dig0;
  } disp_t;

  function automatic logic [6:0] digit_seg(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Tens and units of a value up to 99, packed {tens, units}
  function automatic logic [7:0] split_tens(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(x) * 15'(RECIP_10);
    tens  = prod[RECIP_10_SHIFT +: 4];
    units = x - (7'(tens) * 7'd10);
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mmss_fmt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turns the display state into four digit patterns and the colon.
module mmss_fmt (
  input  wire mmss_pkg::view_t view,
  output mmss_pkg::disp_t      disp
);

  logic [12:0] t_sat;
  logic [25:0] t_prod;
  logic [6:0]  mins_est;
  logic [12:0] rem_est;
  logic [6:0]  mins;
  logic [5:0]  secs;
  logic [7:0]  mins_bcd;
  logic [7:0]  secs_bcd;
  logic [6:0]  val_sat;
  logic [7:0]  val_bcd;
  logic [6:0]  d0, d1, d2, d3;

  always_comb begin
    t_sat = (view.seconds > 16'(mmss_pkg::MAX_SECONDS)) ? mmss_pkg::MAX_SECONDS
                                                         : view.seconds[12:0];
    t_prod   = 26'(t_sat) * 26'(mmss_pkg::RECIP_60);
    mins_est = t_prod[mmss_pkg::RECIP_60_SHIFT +: 7];
    rem_est  = t_sat - (13'(mins_est) * 13'd60);
    // estimate may be one short
    if (rem_est >= 13'd60) begin
      mins = mins_est + 7'd1;
      secs = 6'(rem_est - 13'd60);
    end else begin
      mins = mins_est;
      secs = rem_est[5:0];
    end
    mins_bcd = mmss_pkg::split_tens(mins);
    secs_bcd = mmss_pkg::split_tens({1'b0, secs});

    val_sat = (view.setting_value > 8'(mmss_pkg::MAX_VALUE)) ? mmss_pkg::MAX_VALUE
                                                              : view.setting_value[6:0];
    val_bcd = mmss_pkg::split_tens(val_sat);

    d0 = mmss_pkg::SEG_BLANK;
    d1 = mmss_pkg::SEG_BLANK;
    d2 = mmss_pkg::SEG_BLANK;
    d3 = mmss_pkg::SEG_BLANK;
    if (view.showing_setting) begin
      case (view.setting_id)
        mmss_pkg::SET_PRENOTIFY: begin
          d0 = mmss_pkg::SEG_P;
          d1 = mmss_pkg::SEG_N;
          d2 = mmss_pkg::digit_seg(val_bcd[7:4]);
          d3 = mmss_pkg::digit_seg(val_bcd[3:0]);
        end
        mmss_pkg::SET_LONG, mmss_pkg::SET_EACH_MIN: begin
          d0 = (view.setting_id == mmss_pkg::SET_LONG) ? mmss_pkg::SEG_L
                                                        : mmss_pkg::SEG_E;
          d1 = mmss_pkg::SEG_N;
          d2 = mmss_pkg::SEG_O;
          d3 = (view.setting_value != 8'd0) ? mmss_pkg::SEG_N : mmss_pkg::SEG_F;
        end
        default: begin
          d0 = mmss_pkg::SEG_BLANK;
        end
      endcase
    end else begin
      d0 = mmss_pkg::digit_seg(mins_bcd[7:4]);
      d1 = mmss_pkg::digit_seg(mins_bcd[3:0]);
      d2 = mmss_pkg::digit_seg(secs_bcd[7:4]);
      d3 = mmss_pkg::digit_seg(secs_bcd[3:0]);
    end

    if (view.mode == mmss_pkg::BLINK_MINUTES && !view.phase) begin
      d0 = mmss_pkg::SEG_BLANK;
      d1 = mmss_pkg::SEG_BLANK;
    end
    if (view.mode == mmss_pkg::BLINK_SECONDS && !view.phase) begin
      d2 = mmss_pkg::SEG_BLANK;
      d3 = mmss_pkg::SEG_BLANK;
    end

    disp.dig0  = d0;
    disp.dig1  = d1;
    disp.dig2  = d2;
    disp.dig3  = d3;
    disp.colon = (view.mode != mmss_pkg::BLINK_COLON) || view.phase;
  end

endmodule

`default_nettype wire

// ===== rtl/mmss_seven_segment_blink_formatter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-digit seven-segment MM:SS formatter with blinking. Requests come in on
// the slave stream with the request kind on s_tuser (tick, show time, show
// setting, set blink mode); each request that changes what is visible, and
// each blink phase toggle, produces one refresh on the master stream holding
// the four digit patterns (gfedcba, leftmost digit in the lowest bits) and the
// colon. Repeated shows of an unchanged view and ticks that do not toggle the
// phase produce nothing. Throughput is one request per clock while the master
// stream is not stalled; an accepted request lands in the input register and
// its formatted refresh then in the result register, which presents it on the
// master stream. A stalled refresh holds the request behind it in the input
// register. The blink half period (milliseconds, reset 500) is written through
// cfg_wen/cfg_wdata and may only change while no request is in flight.
module mmss_seven_segment_blink_formatter (
  input  wire        clk,
  input  wire        rst,
  // slave request stream
  input  wire        s_tvalid,
  output logic       s_tready,
  // tdata: time_seconds[15:0], setting_id[17:16], setting_value[25:18],
  //        blink_mode[27:26], blink_start_phase[28], zero pad[31:29]
  input  wire [31:0] s_tdata,
  // tuser: kind[1:0]
  input  wire [1:0]  s_tuser,
  // master refresh stream
  output logic       m_tvalid,
  input  wire        m_tready,
  // tdata: digit0_segments[6:0], digit1_segments[13:7], digit2_segments[20:14],
  //        digit3_segments[27:21], colon_on[28], zero pad[31:29]
  output logic [31:0] m_tdata,
  // blink half period register
  input  wire        cfg_wen,
  input  wire [15:0] cfg_wdata
);

  // input register
  logic        in_valid;
  logic [1:0]  in_kind;
  logic [28:0] in_data;

  // display state
  logic        showing_setting, showing_setting_next;
  logic [15:0] shown_seconds, shown_seconds_next;
  logic [1:0]  shown_setting_id, shown_setting_id_next;
  logic [7:0]  shown_setting_value, shown_setting_value_next;
  logic [1:0]  blink_mode, blink_mode_next;
  logic        blink_phase, blink_phase_next;
  logic [15:0] blink_countdown, blink_countdown_next;
  logic [15:0] half_period;

  logic        emit;
  logic        fire;

  logic [15:0] req_seconds;
  logic [1:0]  req_setting_id;
  logic [7:0]  req_setting_value;
  logic [1:0]  req_mode;
  logic        req_phase;

  mmss_pkg::view_t view_next;
  mmss_pkg::disp_t disp;

  assign req_seconds       = in_data[15:0];
  assign req_setting_id    = in_data[17:16];
  assign req_setting_value = in_data[25:18];
  assign req_mode          = in_data[27:26];
  assign req_phase         = in_data[28];

  // the stage moves whenever the result slot is free or draining
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_data <= s_tdata[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= mmss_pkg::HALF_PERIOD_RESET;
    end else if (cfg_wen) begin
      half_period <= cfg_wdata;
    end
  end

  // request decode
  always_comb begin
    showing_setting_next     = showing_setting;
    shown_seconds_next       = shown_seconds;
    shown_setting_id_next    = shown_setting_id;
    shown_setting_value_next = shown_setting_value;
    blink_mode_next          = blink_mode;
    blink_phase_next         = blink_phase;
    blink_countdown_next     = blink_countdown;
    emit                     = 1'b0;
    case (in_kind)
      mmss_pkg::KIND_TICK: begin
        if (blink_mode != mmss_pkg::BLINK_NONE) begin
          if (blink_countdown != 16'd0) begin
            blink_countdown_next = blink_countdown - 16'd1;
          end else begin
            blink_phase_next     = !blink_phase;
            blink_countdown_next = half_period;
            emit                 = 1'b1;
          end
        end
      end
      mmss_pkg::KIND_SHOW_TIME: begin
        if (showing_setting || shown_seconds != req_seconds) begin
          showing_setting_next = 1'b0;
          shown_seconds_next   = req_seconds;
          emit                 = 1'b1;
        end
      end
      mmss_pkg::KIND_SHOW_SET: begin
        if (!showing_setting || shown_setting_id != req_setting_id ||
            shown_setting_value != req_setting_value) begin
          blink_mode_next          = mmss_pkg::BLINK_SECONDS;
          blink_phase_next         = 1'b1;
          blink_countdown_next     = half_period;
          showing_setting_next     = 1'b1;
          shown_setting_id_next    = req_setting_id;
          shown_setting_value_next = req_setting_value;
          emit                     = 1'b1;
        end
      end
      mmss_pkg::KIND_BLINK: begin
        blink_mode_next = req_mode;
        // mode none keeps phase and countdown as they are
        if (req_mode != mmss_pkg::BLINK_NONE) begin
          blink_phase_next     = req_phase;
          blink_countdown_next = half_period;
        end
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      showing_setting     <= 1'b0;
      shown_seconds       <= 16'd0;
      shown_setting_id    <= 2'd0;
      shown_setting_value <= 8'd0;
      blink_mode          <= mmss_pkg::BLINK_NONE;
      blink_phase         <= 1'b0;
      blink_countdown     <= 16'd0;
    end else if (fire) begin
      showing_setting     <= showing_setting_next;
      shown_seconds       <= shown_seconds_next;
      shown_setting_id    <= shown_setting_id_next;
      shown_setting_value <= shown_setting_value_next;
      blink_mode          <= blink_mode_next;
      blink_phase         <= blink_phase_next;
      blink_countdown     <= blink_countdown_next;
    end
  end

  assign view_next.showing_setting = showing_setting_next;
  assign view_next.seconds         = shown_seconds_next;
  assign view_next.setting_id      = shown_setting_id_next;
  assign view_next.setting_value   = shown_setting_value_next;
  assign view_next.mode            = blink_mode_next;
  assign view_next.phase           = blink_phase_next;

  mmss_fmt u_fmt (
    .view (view_next),
    .disp (disp)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      m_tdata <= {3'b000, disp};
    end
  end

  // a tick with blinking off never refreshes
  a_tick_idle_silent: assert property (@(posedge clk) disable iff (rst)
    fire && in_kind == mmss_pkg::KIND_TICK && blink_mode == mmss_pkg::BLINK_NONE
    |=> !m_tvalid)
    else $error("refresh produced by tick with blinking off");

  // a blink mode request always refreshes
  a_blink_refresh: assert property (@(posedge clk) disable iff (rst)
    fire && in_kind == mmss_pkg::KIND_BLINK |=> m_tvalid)
    else $error("blink mode request produced no refresh");

  // showing a setting leaves the setting view selected
  a_set_view: assert property (@(posedge clk) disable iff (rst)
    fire && in_kind == mmss_pkg::KIND_SHOW_SET |=> showing_setting)
    else $error("setting view not selected after show setting");

  // a dark colon only comes from colon blinking in the off phase
  a_colon_dark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[28] |-> blink_mode == mmss_pkg::BLINK_COLON && !blink_phase)
    else $error("colon dark outside colon blink off phase");

endmodule

`default_nettype wire
